/* hw/rtl/riscv_interrupt_select_and_trap_unit_assert.svh */
// Assertion helpers used by the checker file.
`ifndef RISCV_INTERRUPT_SELECT_AND_TRAP_UNIT_ASSERT_SVH
`define RISCV_INTERRUPT_SELECT_AND_TRAP_UNIT_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define RISTU_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication whose consequent is checked in the next cycle.
`define RISTU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* hw/rtl/ristu_pkg.sv */
`default_nettype none

package ristu_pkg;

    localparam int REG_WIDTH = 32;

    // item kinds
    localparam logic [1:0] KIND_LINE  = 2'd0;
    localparam logic [1:0] KIND_CSR   = 2'd1;
    localparam logic [1:0] KIND_CHECK = 2'd2;

    // CSR views
    localparam logic [1:0] CSR_MIP = 2'd0;
    localparam logic [1:0] CSR_MIE = 2'd1;
    localparam logic [1:0] CSR_SIP = 2'd2;
    localparam logic [1:0] CSR_SIE = 2'd3;

    // privilege levels
    localparam logic [1:0] PRIV_U = 2'd0;
    localparam logic [1:0] PRIV_S = 2'd1;
    localparam logic [1:0] PRIV_M = 2'd3;

    // configuration register indexes
    localparam logic [1:0] CFG_DELEG = 2'd0;
    localparam logic [1:0] CFG_MTVEC = 2'd1;
    localparam logic [1:0] CFG_STVEC = 2'd2;

    localparam logic [REG_WIDTH-1:0] MIP_WRITABLE = REG_WIDTH'('h0000_0AAA);
    localparam logic [REG_WIDTH-1:0] SUPER_VIEW   = REG_WIDTH'('h0000_0222);

    localparam int NUM_PRIO = 6;
    localparam logic [4:0] PRIO_ORDER [NUM_PRIO] = '{5'd11, 5'd3, 5'd7, 5'd9, 5'd1, 5'd5};

    typedef struct packed {
        logic [1:0]           mode;
        logic [4:0]           line_number;
        logic                 line_level;
        logic [1:0]           csr_select;
        logic                 csr_write;
        logic [REG_WIDTH-1:0] csr_write_data;
        logic [1:0]           priv_level;
        logic                 machine_ie;
        logic                 supervisor_ie;
        logic                 global_irq_enable;
        logic [REG_WIDTH-1:0] current_pc;
    } in_item_t;

    typedef struct packed {
        logic [REG_WIDTH-1:0] csr_read_data;
        logic                 interrupt_pending;
        logic                 trap_taken;
        logic                 trap_to_supervisor;
        logic [4:0]           cause_code;
        logic [REG_WIDTH-1:0] target_pc;
        logic [REG_WIDTH-1:0] saved_pc;
        logic [1:0]           saved_priv;
        logic                 saved_ie;
    } out_item_t;

    // Fixed priority first, else lowest set bit.
    function automatic logic [4:0] pick_cause(input logic [REG_WIDTH-1:0] v);
        logic [4:0] c;
        c = '0;
        for (int i = REG_WIDTH - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                c = 5'(i);
            end
        end
        for (int k = NUM_PRIO - 1; k >= 0; k--)
        begin
            if (v[PRIO_ORDER[k]])
            begin
                c = PRIO_ORDER[k];
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/ristu_in_if.sv */
`default_nettype none

interface ristu_in_if;
    logic                valid;
    logic                ready;
    ristu_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ristu_out_if.sv */
`default_nettype none

interface ristu_out_if;
    logic                 valid;
    logic                 ready;
    ristu_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/riscv_interrupt_select_and_trap_unit.sv */
// Channel   Dir  Handshake      Payload
// req       in   valid/ready    ristu_pkg::in_item_t  (line update, CSR access, check)
// rsp       out  valid/ready    ristu_pkg::out_item_t (read data, pending, trap entry)
// cfg       in   cfg_we only    cfg_index selects deleg / mtvec / stvec, cfg_wdata
//
// A transfer on req updates pending/enable and loads the
// result register at the same edge; the result shows on rsp the next cycle.
// Throughput is one item per cycle unless rsp stalls, set by the single result register.
// req.ready drops only while a result sits in that register and rsp.ready is low.
// rst_n (async, active low) clears pending, enable, the config registers and rsp.valid.

`default_nettype none

module riscv_interrupt_select_and_trap_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    ristu_in_if.sink                           req,
    ristu_out_if.source                        rsp,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [ristu_pkg::REG_WIDTH-1:0] cfg_wdata
);

    localparam int W = ristu_pkg::REG_WIDTH;

    // architectural state
    logic [W-1:0] pend_reg, pend_next;
    logic [W-1:0] en_reg,   en_next;
    logic [W-1:0] deleg_reg;
    logic [W-1:0] mtvec_reg;
    logic [W-1:0] stvec_reg;

    // result register
    logic                 rsp_valid_reg;
    ristu_pkg::out_item_t rsp_data_reg, rsp_data_next;

    logic         accept;
    logic [W-1:0] active;
    logic [W-1:0] m_chosen;
    logic [W-1:0] s_chosen;
    logic [W-1:0] chosen;
    logic         m_on;
    logic         s_on;
    logic         to_super;

    // result register frees up as it is taken, so a stall costs no bubble
    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    // Interrupt routing: machine first, supervisor for the delegated ones.
    // Reserved privilege two enables machine but never supervisor interrupts.
    assign active   = en_reg & pend_reg;
    assign m_chosen = active & ~deleg_reg;
    assign s_chosen = active & deleg_reg;
    assign m_on     = (req.data.priv_level == ristu_pkg::PRIV_M) ? req.data.machine_ie : 1'b1;
    assign s_on     = ((req.data.priv_level == ristu_pkg::PRIV_S) && req.data.supervisor_ie)
                      || (req.data.priv_level == ristu_pkg::PRIV_U);
    assign to_super = (m_chosen == '0) || !m_on;
    assign chosen   = to_super ? (s_on ? s_chosen : '0) : m_chosen;

    always_comb
    begin
        pend_next     = pend_reg;
        en_next       = en_reg;
        rsp_data_next = '0;

        case (req.data.mode)
            ristu_pkg::KIND_LINE:
            begin
                // raw line level, no write mask
                pend_next[req.data.line_number] = req.data.line_level;
            end
            ristu_pkg::KIND_CSR:
            begin
                case (req.data.csr_select)
                    ristu_pkg::CSR_MIP:
                    begin
                        if (req.data.csr_write)
                            pend_next = req.data.csr_write_data & ristu_pkg::MIP_WRITABLE;
                        else
                            rsp_data_next.csr_read_data = pend_reg;
                    end
                    ristu_pkg::CSR_MIE:
                    begin
                        if (req.data.csr_write)
                            en_next = req.data.csr_write_data;
                        else
                            rsp_data_next.csr_read_data = en_reg;
                    end
                    ristu_pkg::CSR_SIP:
                    begin
                        if (req.data.csr_write)
                            pend_next = (pend_reg & ~ristu_pkg::SUPER_VIEW)
                                      | (req.data.csr_write_data & ristu_pkg::SUPER_VIEW);
                        else
                            rsp_data_next.csr_read_data = pend_reg & ristu_pkg::SUPER_VIEW;
                    end
                    default:
                    begin
                        if (req.data.csr_write)
                            en_next = (en_reg & ~ristu_pkg::SUPER_VIEW)
                                    | (req.data.csr_write_data & ristu_pkg::SUPER_VIEW);
                        else
                            rsp_data_next.csr_read_data = en_reg & ristu_pkg::SUPER_VIEW;
                    end
                endcase
            end
            ristu_pkg::KIND_CHECK:
            begin
                if (chosen != '0)
                begin
                    rsp_data_next.trap_taken         = 1'b1;
                    rsp_data_next.trap_to_supervisor = to_super;
                    rsp_data_next.cause_code         = ristu_pkg::pick_cause(chosen);
                    rsp_data_next.target_pc          = (to_super ? stvec_reg : mtvec_reg)
                                                       & ~W'(1);
                    rsp_data_next.saved_pc           = req.data.current_pc;
                    rsp_data_next.saved_priv         = req.data.priv_level;
                    rsp_data_next.saved_ie           = req.data.global_irq_enable;
                end
            end
            default:
            begin
                // unused kind: state unchanged, pending flag only
            end
        endcase

        rsp_data_next.interrupt_pending = |(en_next & pend_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            en_reg        <= '0;
            deleg_reg     <= '0;
            mtvec_reg     <= '0;
            stvec_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pend_reg <= pend_next;
                en_reg   <= en_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    ristu_pkg::CFG_DELEG: deleg_reg <= cfg_wdata;
                    ristu_pkg::CFG_MTVEC: mtvec_reg <= cfg_wdata;
                    ristu_pkg::CFG_STVEC: stvec_reg <= cfg_wdata;
                    default:
                    begin
                        // no register here
                    end
                endcase
            end
            if (accept)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_data_reg <= rsp_data_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/ristu_checker.sv */
`default_nettype none

`include "riscv_interrupt_select_and_trap_unit_assert.svh"

module ristu_checker
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 req_valid,
    input wire logic                 req_ready,
    input wire logic                 rsp_valid,
    input wire logic                 rsp_ready,
    input wire ristu_pkg::out_item_t rsp_data
);

    // a stalled result keeps its value
    `RISTU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

    // every transfer in shows a result on the next cycle
    `RISTU_ASSERT_NEXT(a_one_cycle, req_valid && req_ready, rsp_valid)

    // a trap only comes from a check with an enabled pending interrupt, with no read data and an even target pc
    `RISTU_ASSERT_IMPL(a_trap_pending, rsp_valid && rsp_data.trap_taken,
        rsp_data.interrupt_pending && (rsp_data.csr_read_data == '0)
        && !rsp_data.target_pc[0])

    // no trap, no trap entry values
    `RISTU_ASSERT_IMPL(a_no_trap_zero, rsp_valid && !rsp_data.trap_taken,
        (rsp_data.target_pc == '0) && (rsp_data.saved_pc == '0)
        && (rsp_data.cause_code == '0) && !rsp_data.trap_to_supervisor)

endmodule

bind riscv_interrupt_select_and_trap_unit ristu_checker u_ristu_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
